// ===== rtl/adk_pkg.sv =====
package adk_pkg;

  // Fraction bits of the velocity, geometry and gain formats.
  localparam int unsigned VEL_FRAC = 12;
  // Shift from the velocity format to the Q30 angle format.
  localparam int unsigned ANG_SHIFT = 30 - VEL_FRAC;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned TQ_BITS = 47;
  localparam int unsigned QM_BITS = VEL_FRAC + 17;
  localparam int unsigned SERVO_BITS = 15;

  localparam logic [15:0] SERVO_LO = 16'd8192;
  localparam logic [14:0] SERVO_SPAN = 15'd29696;
  localparam logic [15:0] SERVO_CENTER = 16'd25600;
  localparam logic [47:0] SERVO_OFS = 48'd10164633600;
  localparam logic [29:0] DEG_Q24 = 30'd961263669;

  // Everything one command carries down the pipeline.
  typedef struct packed {
    logic                stop;
    logic                neg;
    logic                yz;
    logic                lim;
    logic                near;
    logic                low;
    logic                ovf;
    logic signed [15:0]  v;
    logic signed [15:0]  w;
    logic [15:0]         av;
    logic [15:0]         aw;
    logic [5:0]          k;
    logic signed [43:0]  x;
    logic signed [43:0]  y;
    logic signed [32:0]  z;
    logic [30:0]         ang;
    logic signed [33:0]  rx;
    logic signed [33:0]  ry;
    logic signed [33:0]  ra;
    logic [63:0]         dn;
    logic [31:0]         dd;
    logic [32:0]         dr;
    logic [46:0]         dq;
    logic [46:0]         tq;
    logic [60:0]         dgp;
    logic [22:0]         deg;
    logic [62:0]         prod;
    logic signed [41:0]  slim;
    logic [14:0]         sd;
    logic signed [29:0]  q;
    logic signed [46:0]  side;
    logic signed [47:0]  vl;
    logic signed [47:0]  vr;
    logic [40:0]         hl;
    logic [40:0]         ll;
    logic [40:0]         hr;
    logic [40:0]         lr;
    logic [36:0]         pl;
    logic [36:0]         pr;
  } item_t;

  // Q30 arctangent of 2^-i.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd843314856;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043836;
      5'd3:  a = 30'd133525158;
      5'd4:  a = 30'd67021686;
      5'd5:  a = 30'd33543515;
      5'd6:  a = 30'd16775850;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194282;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048575;
      5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;
      5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;
      5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;
      5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;
      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;
      5'd21: a = 30'd511;
      5'd22: a = 30'd255;
      5'd23: a = 30'd127;
      5'd24: a = 30'd63;
      5'd25: a = 30'd31;
      5'd26: a = 30'd15;
      5'd27: a = 30'd7;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/ackermann_drive_kinematics.sv =====
// Ackermann drive kinematics, fully pipelined: a command beat may be started in
// every clock cycle (busy never rises) and its result appears on the result
// ports, marked by done_o, once it has passed through every stage. The
// pipeline is the row of cells that does the work: 30 vectoring CORDIC
// cells for the steering angle, 30 rotation cells for its tangent, a 47-cell
// and a 29-cell restoring divider and 15 servo search cells, plus 16 stages of
// setup and wheel arithmetic. The receiver cannot hold results off, so
// done_o must be consumed in the cycle it is high. Configuration registers sit
// on the APB port at byte address 4*index; the user must write them only while
// no command is in flight, which the block itself does not enforce.
module ackermann_drive_kinematics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] linear_velocity_i,
  input  logic signed [15:0] angular_velocity_i,
  output logic               done_o,
  output logic               left_forward_o,
  output logic               right_forward_o,
  output logic [15:0]        left_wheel_speed_o,
  output logic [15:0]        right_wheel_speed_o,
  output logic [15:0]        servo_setting_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import adk_pkg::*;

  typedef enum logic [2:0] {
    REG_STOP,
    REG_WBASE,
    REG_MAXSTEER,
    REG_COEFF,
    REG_TRACK,
    REG_LOWLIM,
    REG_LOWGAIN,
    REG_MINSPD
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] stop_thr;
    logic [15:0] wbase;
    logic [12:0] max_steer;
    logic [23:0] coeff;
    logic [15:0] track;
    logic [15:0] low_lim;
    logic [15:0] low_gain;
    logic [15:0] min_spd;
  } cfg_t;

  typedef struct packed {
    logic        fwd;
    logic [15:0] spd;
  } whl_t;

  localparam cfg_t CFG_RESET = '{
    stop_thr:  16'd41,
    wbase:     16'd819,
    max_steer: 13'd2048,
    coeff:     24'd256000,
    track:     16'd614,
    low_lim:   16'd819,
    low_gain:  16'd6144,
    min_spd:   16'd100
  };

  cfg_t cfg_q;

  // ---------------------------------------------------------------------
  // Configuration port. Every write completes in its access cycle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_STOP:     cfg_q.stop_thr  <= pwdata[15:0];
        REG_WBASE:    cfg_q.wbase     <= pwdata[15:0];
        REG_MAXSTEER: cfg_q.max_steer <= pwdata[12:0];
        REG_COEFF:    cfg_q.coeff     <= pwdata[23:0];
        REG_TRACK:    cfg_q.track     <= pwdata[15:0];
        REG_LOWLIM:   cfg_q.low_lim   <= pwdata[15:0];
        REG_LOWGAIN:  cfg_q.low_gain  <= pwdata[15:0];
        REG_MINSPD:   cfg_q.min_spd   <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_STOP:     prdata = 32'(cfg_q.stop_thr);
      REG_WBASE:    prdata = 32'(cfg_q.wbase);
      REG_MAXSTEER: prdata = 32'(cfg_q.max_steer);
      REG_COEFF:    prdata = 32'(cfg_q.coeff);
      REG_TRACK:    prdata = 32'(cfg_q.track);
      REG_LOWLIM:   prdata = 32'(cfg_q.low_lim);
      REG_LOWGAIN:  prdata = 32'(cfg_q.low_gain);
      REG_MINSPD:   prdata = 32'(cfg_q.min_spd);
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // ---------------------------------------------------------------------
  // Front end: magnitudes, stop and low-speed tests, and the y/x pair for the angle.
  // ---------------------------------------------------------------------
  item_t in_d, in_q, mul_d, mul_q, lz_d, lz_q, nrm_d, nrm_q;
  logic  in_vq, mul_vq, lz_vq, nrm_vq;

  always_comb begin
    in_d = '0;
    in_d.v = linear_velocity_i;
    in_d.w = angular_velocity_i;
    in_d.av = linear_velocity_i[15] ? 16'(~linear_velocity_i + 16'sd1)
                                    : linear_velocity_i;
    in_d.aw = angular_velocity_i[15] ? 16'(~angular_velocity_i + 16'sd1)
                                     : angular_velocity_i;
    in_d.stop = (linear_velocity_i == 16'sd0) || (in_d.av < cfg_q.stop_thr);
    in_d.low = in_d.av < cfg_q.low_lim;
  end

  logic [31:0] ywide;

  always_comb begin
    ywide = 32'(in_q.aw) * 32'(cfg_q.wbase);
    mul_d = in_q;
    mul_d.x = $signed(44'(in_q.av) << VEL_FRAC);
    mul_d.y = $signed({12'b0, ywide});
    mul_d.yz = ywide == 32'd0;
    // A zero product gives a zero angle, so the sign only matters otherwise.
    mul_d.neg = (ywide != 32'd0) && (in_q.v[15] != in_q.w[15]);
  end

  logic [31:0] mx;
  logic [5:0]  bl;

  // The angle CORDIC starts from the pair scaled up until one of them
  // reaches bit 40; the shift is found here and applied one stage later.
  always_comb begin
    mx = (mul_q.x[31:0] > mul_q.y[31:0]) ? mul_q.x[31:0] : mul_q.y[31:0];
    bl = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (mx[i]) begin
        bl = 6'(i + 1);
      end
    end
    lz_d = mul_q;
    lz_d.k = 6'd41 - bl;
  end

  always_comb begin
    nrm_d = lz_q;
    nrm_d.x = lz_q.x <<< lz_q.k;
    nrm_d.y = lz_q.y <<< lz_q.k;
    nrm_d.z = '0;
  end

  // ---------------------------------------------------------------------
  // Steering angle: row of vectoring cells.
  // ---------------------------------------------------------------------
  item_t vec_it [CORDIC_STEPS + 1];
  logic  vec_v  [CORDIC_STEPS + 1];

  assign vec_it[0] = nrm_q;
  assign vec_v[0]  = nrm_vq;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    adk_vec_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (5'(i)),
      .vld_i  (vec_v[i]),
      .item_i (vec_it[i]),
      .vld_o  (vec_v[i+1]),
      .item_o (vec_it[i+1])
    );
  end

  // Clamp to the steering limit and decide which yaw rate the wheels use.
  item_t       clp_d, clp_q;
  logic        clp_vq;
  logic [30:0] zz, maxq;

  always_comb begin
    zz = (vec_it[CORDIC_STEPS].yz || vec_it[CORDIC_STEPS].z < 0) ? 31'd0
         : vec_it[CORDIC_STEPS].z[30:0];
    maxq = 31'(cfg_q.max_steer) << ANG_SHIFT;
    clp_d = vec_it[CORDIC_STEPS];
    clp_d.lim = zz > maxq;
    clp_d.ang = clp_d.lim ? maxq : zz;
    clp_d.near = {3'b000, clp_d.ang} < (34'(cfg_q.stop_thr) << ANG_SHIFT);
    clp_d.rx = 34'sh40000000;
    clp_d.ry = '0;
    clp_d.ra = $signed({3'b000, clp_d.ang});
  end

  // ---------------------------------------------------------------------
  // Limited angle: rotation cells give its cosine and sine.
  // ---------------------------------------------------------------------
  item_t rot_it [CORDIC_STEPS + 1];
  logic  rot_v  [CORDIC_STEPS + 1];

  assign rot_it[0] = clp_q;
  assign rot_v[0]  = clp_vq;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    adk_rot_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (5'(i)),
      .vld_i  (rot_v[i]),
      .item_i (rot_it[i]),
      .vld_o  (rot_v[i+1]),
      .item_o (rot_it[i+1])
    );
  end

  // Tangent in Q30 is (s << 30) / c. Quotients of 2^47 or more are caught
  // up front, so the divider only produces the low 47 bits.
  item_t       dv1_d, dv1_q;
  logic        dv1_vq;
  logic [30:0] cc, ss;

  always_comb begin
    cc = (rot_it[CORDIC_STEPS].rx < 1) ? 31'd1 : rot_it[CORDIC_STEPS].rx[30:0];
    ss = rot_it[CORDIC_STEPS].ry[33] ? 31'd0 : rot_it[CORDIC_STEPS].ry[30:0];
    dv1_d = rot_it[CORDIC_STEPS];
    dv1_d.dd = {1'b0, cc};
    dv1_d.dr = 33'(ss >> 17);
    dv1_d.ovf = (ss >> 17) >= cc;
    dv1_d.dn = {ss[16:0], 47'b0};
    dv1_d.dq = '0;
    // Angle to degrees in Q16 for the servo, started here as well.
    dv1_d.dgp = 61'(rot_it[CORDIC_STEPS].ang) * 61'(DEG_Q24);
  end

  item_t d1_it [TQ_BITS + 1];
  logic  d1_v  [TQ_BITS + 1];

  assign d1_it[0] = dv1_q;
  assign d1_v[0]  = dv1_vq;

  for (genvar i = 0; i < TQ_BITS; i++) begin : g_div1
    adk_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (d1_v[i]),
      .item_i (d1_it[i]),
      .vld_o  (d1_v[i+1]),
      .item_o (d1_it[i+1])
    );
  end

  item_t tq_d, tq_q, pm_d, pm_q, dv2_d, dv2_q;
  logic  tq_vq, pm_vq, dv2_vq;

  localparam logic [46:0] TQ_CAP = 47'd1 << 46;

  always_comb begin
    tq_d = d1_it[TQ_BITS];
    tq_d.tq = (d1_it[TQ_BITS].ovf || d1_it[TQ_BITS].dq > TQ_CAP) ? TQ_CAP
              : d1_it[TQ_BITS].dq;
    tq_d.deg = d1_it[TQ_BITS].dgp[60:38];
  end

  logic [41:0] m10;

  always_comb begin
    m10 = 42'(tq_q.deg) * 42'd10000;
    pm_d = tq_q;
    pm_d.prod = 63'(tq_q.av) * 63'(tq_q.tq);
    pm_d.slim = tq_q.neg ? $signed(~m10 + 42'd1) : $signed(m10);
  end

  // Yaw rate that the limited angle allows: (|v| * tan >> 18) / wheelbase.
  logic [44:0] dvd;

  always_comb begin
    dvd = pm_q.prod[62:ANG_SHIFT];
    dv2_d = pm_q;
    dv2_d.dr = 33'(dvd[44:29]);
    dv2_d.dd = 32'(cfg_q.wbase);
    dv2_d.ovf = dvd[44:29] >= cfg_q.wbase;
    dv2_d.dn = {dvd[28:0], 35'b0};
    dv2_d.dq = '0;
    dv2_d.sd = '0;
  end

  item_t d2_it [QM_BITS + 1];
  logic  d2_v  [QM_BITS + 1];

  assign d2_it[0] = dv2_q;
  assign d2_v[0]  = dv2_vq;

  for (genvar i = 0; i < QM_BITS; i++) begin : g_div2
    adk_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (d2_v[i]),
      .item_i (d2_it[i]),
      .vld_o  (d2_v[i+1]),
      .item_o (d2_it[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Servo: bitwise search for the largest calibration point under the
  // angle, most significant offset bit first.
  // ---------------------------------------------------------------------
  item_t sr_it [SERVO_BITS + 1];
  logic  sr_v  [SERVO_BITS + 1];

  assign sr_it[0] = d2_it[QM_BITS];
  assign sr_v[0]  = d2_v[QM_BITS];

  for (genvar i = 0; i < SERVO_BITS; i++) begin : g_srch
    adk_srch_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (4'(SERVO_BITS - 1 - i)),
      .vld_i  (sr_v[i]),
      .item_i (sr_it[i]),
      .vld_o  (sr_v[i+1]),
      .item_o (sr_it[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Wheel arithmetic.
  // ---------------------------------------------------------------------
  item_t q_d, q_q, sd_d, sd_q, sum_d, sum_q, mp_d, mp_q, pc_d, pc_q, gn_d, gn_q;
  logic  q_vq, sd_vq, sum_vq, mp_vq, pc_vq, gn_vq;

  localparam logic [28:0] QM_CAP = 29'd1 << 28;

  logic [28:0] qm;
  item_t       se;

  // The yaw rate is zero near straight ahead, the command itself when the
  // angle is not limited, and the recomputed rate otherwise.
  always_comb begin
    se = sr_it[SERVO_BITS];
    if (cfg_q.wbase == 16'd0) begin
      qm = '0;
    end else if (se.ovf || se.dq[28:0] > QM_CAP) begin
      qm = QM_CAP;
    end else begin
      qm = se.dq[28:0];
    end
    q_d = se;
    if (se.near) begin
      q_d.q = '0;
    end else if (!se.lim) begin
      q_d.q = 30'(se.w);
    end else begin
      q_d.q = se.w[15] ? $signed(~{1'b0, qm} + 30'd1) : $signed({1'b0, qm});
    end
  end

  always_comb begin
    sd_d = q_q;
    sd_d.side = 47'($signed({1'b0, cfg_q.track})) * 47'(q_q.q);
  end

  logic signed [47:0] base;

  always_comb begin
    base = 48'(sd_q.v) <<< (VEL_FRAC + 1);
    sum_d = sd_q;
    sum_d.vl = base - 48'(sd_q.side);
    sum_d.vr = base + 48'(sd_q.side);
  end

  // Magnitude with VEL_FRAC fraction bits times the coefficient, split in two halves.
  logic [47:0] avl, avr;
  logic [33:0] ml, mr;

  always_comb begin
    avl = sum_q.vl[47] ? 48'(~sum_q.vl + 48'sd1) : sum_q.vl;
    avr = sum_q.vr[47] ? 48'(~sum_q.vr + 48'sd1) : sum_q.vr;
    ml = 34'(avl >> VEL_FRAC);
    mr = 34'(avr >> VEL_FRAC);
    mp_d = sum_q;
    mp_d.hl = 41'(cfg_q.coeff) * 41'(ml[33:17]);
    mp_d.ll = 41'(cfg_q.coeff) * 41'(ml[16:0]);
    mp_d.hr = 41'(cfg_q.coeff) * 41'(mr[33:17]);
    mp_d.lr = 41'(cfg_q.coeff) * 41'(mr[16:0]);
  end

  localparam logic [36:0] P_CAP = 37'd1 << 32;

  logic [57:0] prl, prr;

  always_comb begin
    prl = (58'(mp_q.hl) << 17) + 58'(mp_q.ll);
    prr = (58'(mp_q.hr) << 17) + 58'(mp_q.lr);
    pc_d = mp_q;
    pc_d.pl = (prl[57:VEL_FRAC + 9] > P_CAP) ? P_CAP : 37'(prl[57:VEL_FRAC + 9]);
    pc_d.pr = (prr[57:VEL_FRAC + 9] > P_CAP) ? P_CAP : 37'(prr[57:VEL_FRAC + 9]);
  end

  logic [52:0] gl, gr;

  always_comb begin
    gl = 53'(pc_q.pl) * 53'(cfg_q.low_gain);
    gr = 53'(pc_q.pr) * 53'(cfg_q.low_gain);
    gn_d = pc_q;
    if (pc_q.low) begin
      gn_d.pl = 37'(gl >> VEL_FRAC);
      gn_d.pr = 37'(gr >> VEL_FRAC);
    end
  end

  // Final wheel result: a zero wheel value, coefficient or applied low gain reads
  // as forward at zero speed, anything else is lifted to the minimum speed and saturated.
  function automatic whl_t wheel_out(input logic signed [47:0] val,
                                     input logic [36:0] p,
                                     input logic low,
                                     input cfg_t cfg);
    whl_t        r;
    logic [36:0] pm;
    pm = (p < 37'(cfg.min_spd)) ? 37'(cfg.min_spd) : p;
    if (val == 48'sd0 || cfg.coeff == 24'd0 || (low && cfg.low_gain == 16'd0)) begin
      r.fwd = 1'b1;
      r.spd = 16'd0;
    end else begin
      r.fwd = !val[47];
      r.spd = (pm > 37'd65535) ? 16'hffff : pm[15:0];
    end
    return r;
  endfunction

  whl_t wl, wr;

  assign wl = wheel_out(gn_q.vl, gn_q.pl, gn_q.low, cfg_q);
  assign wr = wheel_out(gn_q.vr, gn_q.pr, gn_q.low, cfg_q);

  // ---------------------------------------------------------------------
  // Pipeline registers.
  // ---------------------------------------------------------------------
  logic        done_q;
  logic        lf_q, rf_q;
  logic [15:0] ls_q, rs_q, servo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      mul_vq <= 1'b0;
      lz_vq  <= 1'b0;
      nrm_vq <= 1'b0;
      clp_vq <= 1'b0;
      dv1_vq <= 1'b0;
      tq_vq  <= 1'b0;
      pm_vq  <= 1'b0;
      dv2_vq <= 1'b0;
      q_vq   <= 1'b0;
      sd_vq  <= 1'b0;
      sum_vq <= 1'b0;
      mp_vq  <= 1'b0;
      pc_vq  <= 1'b0;
      gn_vq  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      in_vq  <= start && !busy;
      mul_vq <= in_vq;
      lz_vq  <= mul_vq;
      nrm_vq <= lz_vq;
      clp_vq <= vec_v[CORDIC_STEPS];
      dv1_vq <= rot_v[CORDIC_STEPS];
      tq_vq  <= d1_v[TQ_BITS];
      pm_vq  <= tq_vq;
      dv2_vq <= pm_vq;
      q_vq   <= sr_v[SERVO_BITS];
      sd_vq  <= q_vq;
      sum_vq <= sd_vq;
      mp_vq  <= sum_vq;
      pc_vq  <= mp_vq;
      gn_vq  <= pc_vq;
      done_q <= gn_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    mul_q <= mul_d;
    lz_q  <= lz_d;
    nrm_q <= nrm_d;
    clp_q <= clp_d;
    dv1_q <= dv1_d;
    tq_q  <= tq_d;
    pm_q  <= pm_d;
    dv2_q <= dv2_d;
    q_q   <= q_d;
    sd_q  <= sd_d;
    sum_q <= sum_d;
    mp_q  <= mp_d;
    pc_q  <= pc_d;
    gn_q  <= gn_d;
    // A stopped vehicle reports zero speeds, reverse flags and a centered servo.
    if (gn_q.stop) begin
      lf_q    <= 1'b0;
      rf_q    <= 1'b0;
      ls_q    <= 16'd0;
      rs_q    <= 16'd0;
      servo_q <= SERVO_CENTER;
    end else begin
      lf_q    <= wl.fwd;
      rf_q    <= wr.fwd;
      ls_q    <= wl.spd;
      rs_q    <= wr.spd;
      servo_q <= SERVO_LO + {1'b0, gn_q.sd};
    end
  end

  assign done_o              = done_q;
  assign left_forward_o      = lf_q;
  assign right_forward_o     = rf_q;
  assign left_wheel_speed_o  = ls_q;
  assign right_wheel_speed_o = rs_q;
  assign servo_setting_o     = servo_q;

endmodule

// ===== rtl/adk_vec_cell.sv =====
module adk_vec_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     step_i,
  input  logic           vld_i,
  input  adk_pkg::item_t item_i,
  output logic           vld_o,
  output adk_pkg::item_t item_o
);
  import adk_pkg::*;

  item_t              item_d, item_q;
  logic               vld_q;
  logic signed [43:0] xs, ys;

  // One vectoring step: rotate toward the x axis and collect the angle.
  always_comb begin
    xs = item_i.x >>> step_i;
    ys = item_i.y >>> step_i;
    item_d = item_i;
    if (item_i.y > 0) begin
      item_d.x = item_i.x + ys;
      item_d.y = item_i.y - xs;
      item_d.z = item_i.z + $signed({3'b000, atan_q30(step_i)});
    end else begin
      item_d.x = item_i.x - ys;
      item_d.y = item_i.y + xs;
      item_d.z = item_i.z - $signed({3'b000, atan_q30(step_i)});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== rtl/adk_rot_cell.sv =====
module adk_rot_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     step_i,
  input  logic           vld_i,
  input  adk_pkg::item_t item_i,
  output logic           vld_o,
  output adk_pkg::item_t item_o
);
  import adk_pkg::*;

  item_t              item_d, item_q;
  logic               vld_q;
  logic signed [33:0] xs, ys;

  // One rotation step: turn the vector by the residual angle's sign.
  always_comb begin
    xs = item_i.rx >>> step_i;
    ys = item_i.ry >>> step_i;
    item_d = item_i;
    if (item_i.ra >= 0) begin
      item_d.rx = item_i.rx - ys;
      item_d.ry = item_i.ry + xs;
      item_d.ra = item_i.ra - $signed({4'b0000, atan_q30(step_i)});
    end else begin
      item_d.rx = item_i.rx + ys;
      item_d.ry = item_i.ry - xs;
      item_d.ra = item_i.ra + $signed({4'b0000, atan_q30(step_i)});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== rtl/adk_div_cell.sv =====
module adk_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  adk_pkg::item_t item_i,
  output logic           vld_o,
  output adk_pkg::item_t item_o
);
  import adk_pkg::*;

  item_t       item_d, item_q;
  logic        vld_q;
  logic [32:0] r2;
  logic        ge;

  // One restoring division step: bring in the next dividend bit.
  always_comb begin
    r2 = {item_i.dr[31:0], item_i.dn[63]};
    ge = r2 >= {1'b0, item_i.dd};
    item_d = item_i;
    item_d.dr = ge ? r2 - {1'b0, item_i.dd} : r2;
    item_d.dn = {item_i.dn[62:0], 1'b0};
    item_d.dq = {item_i.dq[45:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== rtl/adk_srch_cell.sv =====
module adk_srch_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     step_i,
  input  logic           vld_i,
  input  adk_pkg::item_t item_i,
  output logic           vld_o,
  output adk_pkg::item_t item_o
);
  import adk_pkg::*;

  item_t              item_d, item_q;
  logic               vld_q;
  logic [14:0]        cand;
  logic [15:0]        p;
  logic [31:0]        sq;
  logic signed [47:0] fval;
  logic signed [47:0] lim48;

  // Tries one more bit of the servo offset against the calibration curve.
  always_comb begin
    cand  = item_i.sd | (15'd1 << step_i);
    p     = SERVO_LO + {1'b0, cand};
    sq    = 32'(p) * 32'(p);
    fval  = 48'(sq) * 48'd11 + 48'(p) * 48'd115456 - SERVO_OFS;
    lim48 = 48'(item_i.slim);
    item_d = item_i;
    if ((cand <= SERVO_SPAN) && (fval <= lim48)) begin
      item_d.sd = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
